>>> rtl/core/hsc_pkg.sv
// Package for the Hamming syndrome codec: beat types, job type and field codes.
// Has no dependencies. The front, queue, back and top-level modules use it.
package hsc_pkg;

  localparam int unsigned SYN_W = 16;  // width of the syndrome field
  localparam int unsigned NB_W  = 5;   // holds a parity-bit count of up to SYN_W

  localparam logic ACT_DATA  = 1'b0;
  localparam logic ACT_CHECK = 1'b1;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_CHECK  = 1'b1;

  localparam logic KIND_PARITY = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [1:0] ST_CLEAN      = 2'd0;
  localparam logic [1:0] ST_SINGLE     = 2'd1;
  localparam logic [1:0] ST_BEYOND     = 2'd2;
  localparam logic [1:0] ST_WRONG_SIZE = 2'd3;

  typedef struct packed {
    logic action;
    logic bit_value;
    logic last;
  } in_item_t;

  typedef struct packed {
    logic             kind;
    logic             parity_bit;
    logic [SYN_W-1:0] syndrome;
    logic [1:0]       status;
    logic             end_of_run;
  } out_item_t;

  // One finished word: either a run of parity bits or one status result.
  typedef struct packed {
    logic             is_status;
    logic [SYN_W-1:0] data;    // parity accumulator or syndrome
    logic [NB_W-1:0]  nbits;   // parity bits to emit
    logic [1:0]       status;
  } job_t;

endpackage

>>> rtl/core/hsc_front.sv
// Front end of the Hamming syndrome codec: takes code bits, keeps the word state
// and turns each finished word into a job. Depends on hsc_pkg.
module hsc_front #(
  parameter int unsigned MAX_DATA_BITS = 1024
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  hsc_pkg::in_item_t in_data_i,
  input  logic            q_full_i,
  output logic            q_push_o,
  output hsc_pkg::job_t   q_job_o
);

  localparam int unsigned CNT_W = $clog2(MAX_DATA_BITS + 1);
  localparam int unsigned IDX_W = $clog2(CNT_W + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DATA_BITS);
  localparam logic [IDX_W-1:0] IDX_MAX = '1;

  function automatic logic [IDX_W-1:0] bit_len(input logic [CNT_W-1:0] v);
    logic [IDX_W-1:0] n;
    n = '0;
    for (int unsigned i = 0; i < CNT_W; i++) begin
      if (v[i]) begin
        n = IDX_W'(i + 1);
      end
    end
    return n;
  endfunction

  logic             mode_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] acc_q, acc_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] stored_q, stored_d;

  logic             in_fire;
  logic             cnt_inc;
  logic [CNT_W-1:0] cnt_nxt, acc_nxt, stored_nxt, mask, syn;
  logic [IDX_W-1:0] idx_nxt, need_enc, need_chk;

  assign in_ready_o = !q_full_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    cnt_inc  = (cnt_q != MAX_CNT);
    cnt_nxt  = cnt_inc ? cnt_q + CNT_W'(1) : cnt_q;
    acc_nxt  = (cnt_inc && in_data_i.bit_value) ? (acc_q ^ cnt_nxt) : acc_q;
    need_enc = bit_len(cnt_nxt);
    need_chk = bit_len(cnt_q);

    stored_nxt = stored_q;
    for (int unsigned i = 0; i < CNT_W; i++) begin
      if (idx_q == IDX_W'(i) && in_data_i.bit_value) begin
        stored_nxt[i] = 1'b1;
      end
      mask[i] = (IDX_W'(i) < need_chk);
    end
    idx_nxt = (idx_q == IDX_MAX) ? idx_q : idx_q + IDX_W'(1);
    syn     = (acc_q ^ stored_nxt) & mask;
  end

  always_comb begin
    cnt_d    = cnt_q;
    acc_d    = acc_q;
    idx_d    = idx_q;
    stored_d = stored_q;
    q_push_o = 1'b0;
    q_job_o  = '0;
    if (in_fire) begin
      if (in_data_i.action == hsc_pkg::ACT_DATA) begin
        cnt_d = cnt_nxt;
        acc_d = acc_nxt;
        if (in_data_i.last && mode_q == hsc_pkg::MODE_ENCODE) begin
          q_push_o          = 1'b1;
          q_job_o.is_status = 1'b0;
          q_job_o.data      = hsc_pkg::SYN_W'(acc_nxt);
          q_job_o.nbits     = hsc_pkg::NB_W'(need_enc);
          cnt_d             = '0;
          acc_d             = '0;
          idx_d             = '0;
          stored_d          = '0;
        end
      end else if (mode_q == hsc_pkg::MODE_CHECK) begin
        idx_d    = idx_nxt;
        stored_d = stored_nxt;
        if (in_data_i.last) begin
          q_push_o          = 1'b1;
          q_job_o.is_status = 1'b1;
          if (cnt_q == '0 || idx_nxt < need_chk) begin
            q_job_o.status = hsc_pkg::ST_WRONG_SIZE;
          end else begin
            q_job_o.data = hsc_pkg::SYN_W'(syn);
            if (syn == '0) begin
              q_job_o.status = hsc_pkg::ST_CLEAN;
            end else if (syn <= cnt_q) begin
              q_job_o.status = hsc_pkg::ST_SINGLE;
            end else begin
              q_job_o.status = hsc_pkg::ST_BEYOND;
            end
          end
          cnt_d    = '0;
          acc_d    = '0;
          idx_d    = '0;
          stored_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= hsc_pkg::MODE_ENCODE;
      cnt_q    <= '0;
      acc_q    <= '0;
      idx_q    <= '0;
      stored_q <= '0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      cnt_q    <= cnt_d;
      acc_q    <= acc_d;
      idx_q    <= idx_d;
      stored_q <= stored_d;
    end
  end

endmodule

>>> rtl/core/hsc_queue.sv
// Short job queue between the front and back of the Hamming syndrome codec.
// Registers only; depends on hsc_pkg for the job type.
module hsc_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  hsc_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output hsc_pkg::job_t job_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  hsc_pkg::job_t    slot_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == DEPTH_CNT);
  assign valid_o = (cnt_q != '0);
  assign job_o   = slot_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == LAST_PTR) ? '0 : wptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == LAST_PTR) ? '0 : rptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o || pop_i)
    else $error("job pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("job popped from an empty queue");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DEPTH_CNT)
    else $error("queue fill count out of range");

endmodule

>>> rtl/core/hsc_back.sv
// Back end of the Hamming syndrome codec: expands jobs into result beats and
// holds them in the output register. Depends on hsc_pkg.
module hsc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  hsc_pkg::job_t      q_job_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output hsc_pkg::out_item_t out_data_o
);

  logic                      out_valid_q, out_valid_d;
  hsc_pkg::out_item_t        out_q, out_d;
  logic [hsc_pkg::NB_W-1:0]  rem_q, rem_d;
  logic [hsc_pkg::SYN_W-1:0] shf_q, shf_d;
  logic                      load;

  assign load        = !out_valid_q || out_ready_i;
  assign q_pop_o     = load && (rem_q == '0) && q_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    rem_d       = rem_q;
    shf_d       = shf_q;
    if (load) begin
      out_d = '0;
      if (rem_q != '0) begin
        // Continue the parity run of the current word.
        out_valid_d      = 1'b1;
        out_d.kind       = hsc_pkg::KIND_PARITY;
        out_d.parity_bit = shf_q[0];
        out_d.end_of_run = (rem_q == hsc_pkg::NB_W'(1));
        shf_d            = shf_q >> 1;
        rem_d            = rem_q - hsc_pkg::NB_W'(1);
      end else if (q_valid_i) begin
        out_valid_d = 1'b1;
        if (q_job_i.is_status) begin
          out_d.kind       = hsc_pkg::KIND_STATUS;
          out_d.syndrome   = q_job_i.data;
          out_d.status     = q_job_i.status;
          out_d.end_of_run = 1'b1;
        end else begin
          out_d.kind       = hsc_pkg::KIND_PARITY;
          out_d.parity_bit = q_job_i.data[0];
          out_d.end_of_run = (q_job_i.nbits == hsc_pkg::NB_W'(1));
          shf_d            = q_job_i.data >> 1;
          rem_d            = q_job_i.nbits - hsc_pkg::NB_W'(1);
        end
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    shf_q <= shf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      rem_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      rem_q       <= rem_d;
    end
  end

  a_run_has_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q != '0 |-> out_valid_q && out_q.kind == hsc_pkg::KIND_PARITY
      && !out_q.end_of_run)
    else $error("parity run pending without an open parity beat");

endmodule

>>> rtl/core/hamming_syndrome_codec.sv
// Hamming syndrome codec top level: front end, job queue and back end.
// Depends on hsc_pkg, hsc_front, hsc_queue and hsc_back.
//
// Usage:
//   Code bits enter one per beat on the in channel (action, bit_value, last).
//   The mode register (cfg_we_i/cfg_wdata_i) selects encode or check; write it
//   only while the block is idle. In encode mode the last data bit of a word
//   produces one parity beat per check bit, lowest index first, the final one
//   flagged end_of_run. In check mode the last stored check bit produces one
//   status beat carrying the syndrome and status.
//   Throughput: one input beat per cycle while the job queue is not full. The front
//   end does one XOR and one increment per data bit. The back end sends one result
//   beat per cycle while the receiver is ready.
//   Path: the job of a word is written into the queue when its last input beat
//   is accepted, and the back end moves it into the output register once the
//   earlier result beats are sent and the output register is free.
//   Stalls: a two-entry queue of finished words sits between front and back.
//   When the receiver stalls and the queue fills, in_ready_o drops.
//   Reset clears the mode to encode, the word state, the queue and the output.
module hamming_syndrome_codec #(
  parameter int unsigned MAX_DATA_BITS = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  hsc_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output hsc_pkg::out_item_t out_data_o
);

  logic          q_full, q_push, q_pop, q_valid;
  hsc_pkg::job_t job_in, job_out;

  hsc_front #(
    .MAX_DATA_BITS(MAX_DATA_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_job_o    (job_in)
  );

  hsc_queue #(
    .DEPTH(2)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .job_i  (job_in),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .job_o  (job_out)
  );

  hsc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_job_i    (job_out),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule
